### hw/rtl/blg_pkg.sv
package blg_pkg;

	// timing constants, in ticks
	localparam logic [8:0]  STARTUP_DELAY   = 9'd500;
	localparam logic [14:0] SLEW_TICKS      = 15'd30000;
	localparam logic [11:0] LOW_DELAY       = 12'd3000;
	localparam logic [15:0] CHARGE_FULL_MIN = 16'd30;
	localparam logic [15:0] UNFULL_DELAY    = 16'd3000;
	localparam logic [14:0] LOW_STEP_TICKS  = 15'd200;

	// charge timer rollover points
	localparam logic [9:0] MS_PER_SEC  = 10'd1000;
	localparam logic [5:0] SEC_PER_MIN = 6'd60;

	// sample above which a completed minute sets the charge timer to the full mark
	localparam logic [11:0] FULL_V_LIMIT = 12'd850;

	// bar levels with a meaning of their own
	localparam logic [2:0] LEVEL_TOP  = 3'd4;
	localparam logic [2:0] LEVEL_FULL = 3'd5;
	localparam logic [2:0] LEVEL_LAST_PARTIAL = 3'd3;

	// register map
	localparam int unsigned NUM_REGS = 8;
	typedef enum logic [2:0] {
		REG_BAT_THRESH_0 = 3'd0,
		REG_BAT_THRESH_1 = 3'd1,
		REG_BAT_THRESH_2 = 3'd2,
		REG_BAT_THRESH_3 = 3'd3,
		REG_CHG_THRESH_0 = 3'd4,
		REG_CHG_THRESH_1 = 3'd5,
		REG_CHG_THRESH_2 = 3'd6,
		REG_CHG_THRESH_3 = 3'd7
	} blg_reg_t;

	typedef logic [11:0] thresh_t;

	// classifier output
	typedef struct packed {
		logic [2:0] level;
		logic       at_full_v;
	} blg_raw_t;

	// one result item
	typedef struct packed {
		logic       sys_event;
		logic       low_battery;
		logic       motor_stop;
		logic [2:0] shown_level;
	} blg_result_t;

endpackage

### hw/rtl/battery_level_gauge.sv
// Battery bar-level gauge. Each input beat is one millisecond tick carrying a
// 12-bit battery sample and the charging flag; each beat yields exactly one
// output beat with the shown level (0..4, 5 = charge full), the motor stop
// request, the low-battery latch and a one-tick system event. A beat is
// registered on entry, then the classifier and the gauge state update run
// combinationally into the output register, so one beat per clock is
// sustained while the result side accepts. The user must write the eight
// thresholds through the cfg port (index 0..3 discharge, 4..7 charging)
// only while no beat is in flight; the block itself does not enforce this.
module battery_level_gauge (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] vin_sample, [12] charging, [15:13] zero
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] shown_level_out, [3] motor_stop,
	                               // [4] low_battery, [5] sys_event, [7:6] zero
	// threshold writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	blg_pkg::thresh_t     thresh_q [blg_pkg::NUM_REGS];
	blg_pkg::thresh_t     bat_thresh [4];
	blg_pkg::thresh_t     chg_thresh [4];
	logic                 valid_s1;
	logic [11:0]          vin_s1;
	logic                 chg_s1;
	logic                 out_valid_q;
	blg_pkg::blg_result_t out_q;
	blg_pkg::blg_result_t result;
	blg_pkg::blg_raw_t    raw;
	logic                 advance;

	assign cfg_ready = 1'b1;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q[blg_pkg::REG_BAT_THRESH_0] <= 12'd600;
			thresh_q[blg_pkg::REG_BAT_THRESH_1] <= 12'd650;
			thresh_q[blg_pkg::REG_BAT_THRESH_2] <= 12'd700;
			thresh_q[blg_pkg::REG_BAT_THRESH_3] <= 12'd750;
			thresh_q[blg_pkg::REG_CHG_THRESH_0] <= 12'd700;
			thresh_q[blg_pkg::REG_CHG_THRESH_1] <= 12'd750;
			thresh_q[blg_pkg::REG_CHG_THRESH_2] <= 12'd800;
			thresh_q[blg_pkg::REG_CHG_THRESH_3] <= 12'd850;
		end else if (cfg_valid) begin
			thresh_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bat_thresh[i] = thresh_q[i];
			chg_thresh[i] = thresh_q[i + 4];
		end
	end

	// stage handshake
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			vin_s1 <= s_tdata[11:0];
			chg_s1 <= s_tdata[12];
		end
	end

	blg_classify u_classify (
		.vin_sample (vin_s1),
		.charging   (chg_s1),
		.bat_thresh (bat_thresh),
		.chg_thresh (chg_thresh),
		.raw        (raw)
	);

	blg_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.vin_sample (vin_s1),
		.charging   (chg_s1),
		.raw        (raw),
		.result     (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.sys_event, out_q.low_battery, out_q.motor_stop,
		out_q.shown_level};

endmodule

### hw/rtl/blg_classify.sv
module blg_classify (
	input  logic [11:0]         vin_sample,
	input  logic                charging,
	input  blg_pkg::thresh_t    bat_thresh [4],
	input  blg_pkg::thresh_t    chg_thresh [4],
	output blg_pkg::blg_raw_t   raw
);

	// first bound not exceeded wins, in list order
	always_comb begin
		raw.level     = blg_pkg::LEVEL_TOP;
		raw.at_full_v = 1'b0;
		if (charging) begin
			priority if (vin_sample <= chg_thresh[0]) raw.level = 3'd1;
			else if (vin_sample <= chg_thresh[1]) raw.level = 3'd2;
			else if (vin_sample <= chg_thresh[2]) raw.level = 3'd3;
			else if (vin_sample <= chg_thresh[3]) raw.level = 3'd4;
			else raw.at_full_v = 1'b1;
		end else begin
			priority if (vin_sample <= bat_thresh[0]) raw.level = 3'd0;
			else if (vin_sample <= bat_thresh[1]) raw.level = 3'd1;
			else if (vin_sample <= bat_thresh[2]) raw.level = 3'd2;
			else if (vin_sample <= bat_thresh[3]) raw.level = 3'd3;
			else raw.level = blg_pkg::LEVEL_TOP;
		end
	end

endmodule

### hw/rtl/blg_tracker.sv
module blg_tracker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [11:0]          vin_sample,
	input  logic                 charging,
	input  blg_pkg::blg_raw_t    raw,
	output blg_pkg::blg_result_t result
);

	logic [8:0]  startup_q, startup_n;
	logic [2:0]  level_q, level_n;
	logic        low_q, low_n;
	logic [14:0] slew_q, slew_n;
	logic [11:0] low_cnt_q, low_cnt_n;
	logic [15:0] unfull_q, unfull_n;
	logic [9:0]  ms_q, ms_n;
	logic [5:0]  sec_q, sec_n;
	logic [15:0] min_q, min_n;
	logic        once_q, once_n;

	logic [15:0] slew_inc;
	logic [12:0] low_inc;
	logic [15:0] unfull_dec;
	logic        stop;
	logic        ev;

	// next state for one tick
	always_comb begin
		startup_n = startup_q;
		level_n   = level_q;
		low_n     = low_q;
		slew_n    = slew_q;
		low_cnt_n = low_cnt_q;
		unfull_n  = unfull_q;
		ms_n      = ms_q;
		sec_n     = sec_q;
		min_n     = min_q;
		once_n    = once_q;
		stop      = 1'b0;
		ev        = 1'b0;
		slew_inc  = {1'b0, slew_q} + 16'd1;
		low_inc   = {1'b0, low_cnt_q} + 13'd1;
		unfull_dec = unfull_q - 16'd1;

		// level tracking
		if (startup_q != 9'd0) begin
			startup_n = startup_q - 9'd1;
			level_n   = raw.level;
		end else if (low_q) begin
			stop = 1'b1;
			if (slew_inc > {1'b0, blg_pkg::LOW_STEP_TICKS}) begin
				slew_n = '0;
				if (level_q != 3'd0) level_n = level_q - 3'd1;
			end else begin
				slew_n = slew_inc[14:0];
			end
		end else if (raw.level != 3'd0) begin
			low_cnt_n = '0;
			if (level_q != raw.level) begin
				if (slew_inc > {1'b0, blg_pkg::SLEW_TICKS}) begin
					slew_n = '0;
					if (level_q < raw.level) level_n = level_q + 3'd1;
					else level_n = level_q - 3'd1;
				end else begin
					slew_n = slew_inc[14:0];
				end
			end else begin
				slew_n = '0;
			end
		end else begin
			if (low_inc > {1'b0, blg_pkg::LOW_DELAY}) begin
				low_cnt_n = blg_pkg::LOW_DELAY;
				if (!charging) begin
					low_n = 1'b1;
					stop  = 1'b1;
				end
			end else begin
				low_cnt_n = low_inc[11:0];
			end
		end

		// charge-full timer
		if (charging) begin
			if (min_q >= blg_pkg::CHARGE_FULL_MIN) begin
				min_n    = blg_pkg::CHARGE_FULL_MIN;
				unfull_n = blg_pkg::UNFULL_DELAY;
				level_n  = blg_pkg::LEVEL_FULL;
			end else if (level_n == blg_pkg::LEVEL_TOP && raw.at_full_v) begin
				ms_n = ms_q + 10'd1;
				if (ms_n >= blg_pkg::MS_PER_SEC) begin
					ms_n  = '0;
					sec_n = sec_q + 6'd1;
				end
				if (sec_n >= blg_pkg::SEC_PER_MIN) begin
					sec_n = '0;
					min_n = min_q + 16'd1;
					if (vin_sample > blg_pkg::FULL_V_LIMIT) min_n = blg_pkg::CHARGE_FULL_MIN;
					ev = 1'b1;
				end
			end
		end

		// unfull delay
		if (raw.level <= blg_pkg::LEVEL_LAST_PARTIAL && startup_n == 9'd0) begin
			ms_n  = '0;
			sec_n = '0;
			min_n = '0;
			if (unfull_n != 16'd0) begin
				unfull_dec = unfull_n - 16'd1;
				unfull_n   = unfull_dec;
				if (unfull_dec == 16'd0) level_n = raw.level;
				once_n = 1'b1;
			end else if (once_q) begin
				once_n = 1'b0;
				ev     = 1'b1;
			end
		end else begin
			once_n   = 1'b1;
			unfull_n = blg_pkg::UNFULL_DELAY;
		end

		result.shown_level = level_n;
		result.motor_stop  = stop;
		result.low_battery = low_n;
		result.sys_event   = ev;
	end

	// gauge state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_q <= blg_pkg::STARTUP_DELAY;
			level_q   <= '0;
			low_q     <= 1'b0;
			slew_q    <= '0;
			low_cnt_q <= '0;
			unfull_q  <= blg_pkg::UNFULL_DELAY;
			ms_q      <= '0;
			sec_q     <= '0;
			min_q     <= '0;
			once_q    <= 1'b0;
		end else if (step) begin
			startup_q <= startup_n;
			level_q   <= level_n;
			low_q     <= low_n;
			slew_q    <= slew_n;
			low_cnt_q <= low_cnt_n;
			unfull_q  <= unfull_n;
			ms_q      <= ms_n;
			sec_q     <= sec_n;
			min_q     <= min_n;
			once_q    <= once_n;
		end
	end

endmodule

### sim/battery_level_gauge_checker.sv
`timescale 1ns / 100ps

module battery_level_gauge_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,    // [11:0] vin_sample, [12] charging, [15:13] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,    // [2:0] shown_level_out, [3] motor_stop,
	                                // [4] low_battery, [5] sys_event, [7:6] zero
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int          bad_readings,
	output int          readings_owed
);

	// shadow of the threshold registers
	blg_pkg::thresh_t thr [blg_pkg::NUM_REGS];

	// shadow of the gauge state
	logic [8:0]  startup_left;
	logic [2:0]  bar;
	logic        low_latch;
	logic [14:0] slew_cnt;
	logic [11:0] low_cnt;
	logic [15:0] unfull_left;
	logic [9:0]  chg_ms;
	logic [5:0]  chg_sec;
	logic [15:0] chg_min;
	logic        unfull_armed;

	blg_pkg::blg_result_t readings_due [$];
	blg_pkg::blg_result_t got;
	blg_pkg::blg_result_t want;
	int                   beat_no;

	// advance the gauge by one millisecond tick and return the reading it shows
	function automatic blg_pkg::blg_result_t gauge_tick(input logic [11:0] vin,
	                                                    input logic chg);
		blg_pkg::blg_result_t res;
		logic [2:0]  raw;
		logic        full_v;
		logic        stop;
		logic        ev;
		int          k;
		stop = 1'b0;
		ev = 1'b0;
		raw = blg_pkg::LEVEL_TOP;
		full_v = chg;
		// first bound not exceeded wins, so scan from the top and keep the lowest hit
		for (k = 3; k >= 0; k--) begin
			if (chg) begin
				if (vin <= thr[blg_pkg::REG_CHG_THRESH_0 + k]) begin
					raw = 3'(k + 1);
					full_v = 1'b0;
				end
			end else if (vin <= thr[blg_pkg::REG_BAT_THRESH_0 + k]) begin
				raw = 3'(k);
			end
		end

		// shown level: start-up copy, low-battery countdown, slew or low detection
		if (startup_left != 9'd0) begin
			startup_left = startup_left - 9'd1;
			bar = raw;
		end else if (low_latch) begin
			stop = 1'b1;
			slew_cnt = slew_cnt + 15'd1;
			if (slew_cnt > blg_pkg::LOW_STEP_TICKS) begin
				slew_cnt = 15'd0;
				if (bar != 3'd0)
					bar = bar - 3'd1;
			end
		end else if (raw != 3'd0) begin
			low_cnt = 12'd0;
			if (bar != raw) begin
				slew_cnt = slew_cnt + 15'd1;
				if (slew_cnt > blg_pkg::SLEW_TICKS) begin
					slew_cnt = 15'd0;
					if (bar < raw)
						bar = bar + 3'd1;
					else
						bar = bar - 3'd1;
				end
			end else begin
				slew_cnt = 15'd0;
			end
		end else begin
			low_cnt = low_cnt + 12'd1;
			if (low_cnt > blg_pkg::LOW_DELAY) begin
				low_cnt = blg_pkg::LOW_DELAY;
				if (!chg) begin
					low_latch = 1'b1;
					stop = 1'b1;
				end
			end
		end

		// charge timer toward full
		if (chg) begin
			if (chg_min >= blg_pkg::CHARGE_FULL_MIN) begin
				chg_min = blg_pkg::CHARGE_FULL_MIN;
				unfull_left = blg_pkg::UNFULL_DELAY;
				bar = blg_pkg::LEVEL_FULL;
			end else if (bar == blg_pkg::LEVEL_TOP && full_v) begin
				chg_ms = chg_ms + 10'd1;
				if (chg_ms >= blg_pkg::MS_PER_SEC) begin
					chg_ms = 10'd0;
					chg_sec = chg_sec + 6'd1;
				end
				if (chg_sec >= blg_pkg::SEC_PER_MIN) begin
					chg_sec = 6'd0;
					chg_min = chg_min + 16'd1;
					if (vin > blg_pkg::FULL_V_LIMIT)
						chg_min = blg_pkg::CHARGE_FULL_MIN;
					ev = 1'b1;
				end
			end
		end

		// unfull delay after the level drops below the top
		if (raw <= blg_pkg::LEVEL_LAST_PARTIAL && startup_left == 9'd0) begin
			chg_ms = 10'd0;
			chg_sec = 6'd0;
			chg_min = 16'd0;
			if (unfull_left != 16'd0) begin
				unfull_left = unfull_left - 16'd1;
				if (unfull_left == 16'd0)
					bar = raw;
				unfull_armed = 1'b1;
			end else if (unfull_armed) begin
				unfull_armed = 1'b0;
				ev = 1'b1;
			end
		end else begin
			unfull_armed = 1'b1;
			unfull_left = blg_pkg::UNFULL_DELAY;
		end

		res.shown_level = bar;
		res.motor_stop = stop;
		res.low_battery = low_latch;
		res.sys_event = ev;
		return res;
	endfunction

	// watch all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr[blg_pkg::REG_BAT_THRESH_0] = 12'd600;
			thr[blg_pkg::REG_BAT_THRESH_1] = 12'd650;
			thr[blg_pkg::REG_BAT_THRESH_2] = 12'd700;
			thr[blg_pkg::REG_BAT_THRESH_3] = 12'd750;
			thr[blg_pkg::REG_CHG_THRESH_0] = 12'd700;
			thr[blg_pkg::REG_CHG_THRESH_1] = 12'd750;
			thr[blg_pkg::REG_CHG_THRESH_2] = 12'd800;
			thr[blg_pkg::REG_CHG_THRESH_3] = 12'd850;
			startup_left = blg_pkg::STARTUP_DELAY;
			bar = 3'd0;
			low_latch = 1'b0;
			slew_cnt = 15'd0;
			low_cnt = 12'd0;
			unfull_left = blg_pkg::UNFULL_DELAY;
			chg_ms = 10'd0;
			chg_sec = 6'd0;
			chg_min = 16'd0;
			unfull_armed = 1'b0;
			readings_due.delete();
			bad_readings = 0;
			readings_owed = 0;
			beat_no = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				thr[cfg_index] = cfg_data;

			if (s_tvalid && s_tready)
				readings_due.push_back(gauge_tick(s_tdata[11:0], s_tdata[12]));

			// compare each result beat with the oldest expected reading
			if (m_tvalid && m_tready) begin
				got = blg_pkg::blg_result_t'(m_tdata[5:0]);
				if (readings_due.size() == 0) begin
					bad_readings++;
					if (bad_readings <= 10)
						$display("beat %0d unexpected: level %0d stop %b low %b event %b",
							beat_no, got.shown_level, got.motor_stop, got.low_battery,
							got.sys_event);
				end else begin
					want = readings_due.pop_front();
					if (got.shown_level !== want.shown_level ||
					    got.motor_stop !== want.motor_stop ||
					    got.low_battery !== want.low_battery ||
					    got.sys_event !== want.sys_event) begin
						bad_readings++;
						if (bad_readings <= 10)
							$display("beat %0d: expected level %0d stop %b low %b event %b,",
								beat_no, want.shown_level, want.motor_stop,
								want.low_battery, want.sys_event,
								" got level %0d stop %b low %b event %b",
								got.shown_level, got.motor_stop, got.low_battery,
								got.sys_event);
					end
				end
				beat_no++;
			end
			readings_owed = readings_due.size();
		end
	end

endmodule

### sim/battery_level_gauge_tb.sv
`timescale 1ns / 100ps

module battery_level_gauge_tb;

	localparam int unsigned CYCLE_LIMIT = 10000000;

	typedef enum {SINK_OPEN, SINK_BUSY, SINK_CHOKED, SINK_PERIODIC} sink_style_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [11:0] vin_sample, [12] charging, [15:13] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [2:0] shown_level_out, [3] motor_stop,
	                        // [4] low_battery, [5] sys_event, [7:6] zero
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [11:0] cfg_data;

	int          bad_readings;
	int          readings_owed;
	int unsigned ticks_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;

	battery_level_gauge u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	battery_level_gauge_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.bad_readings  (bad_readings),
		.readings_owed (readings_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one tick beat; bursts of random length with random gaps between them
	task automatic send_tick(input logic [11:0] vin, input logic chg);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0) begin
				gap = 0;
				burst_left = $urandom_range(500, 3000);
			end else begin
				gap = $urandom_range(0, 5);
				burst_left = $urandom_range(1, 48);
			end
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, chg, vin};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
	endtask

	// ticks with samples drawn from one band
	task automatic send_band(input int unsigned n, input int unsigned lo, input int unsigned hi,
	                         input logic chg);
		repeat (n) send_tick(12'($urandom_range(lo, hi)), chg);
	endtask

	// ticks with any sample and any charging flag
	task automatic send_noise(input int unsigned n);
		repeat (n) send_tick(12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
	endtask

	// stop offering and wait until every reading has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (readings_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_thresh(input blg_pkg::blg_reg_t idx, input blg_pkg::thresh_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_thresholds(input blg_pkg::thresh_t b0, input blg_pkg::thresh_t b1,
	                               input blg_pkg::thresh_t b2, input blg_pkg::thresh_t b3,
	                               input blg_pkg::thresh_t c0, input blg_pkg::thresh_t c1,
	                               input blg_pkg::thresh_t c2, input blg_pkg::thresh_t c3);
		write_thresh(blg_pkg::REG_BAT_THRESH_0, b0);
		write_thresh(blg_pkg::REG_BAT_THRESH_1, b1);
		write_thresh(blg_pkg::REG_BAT_THRESH_2, b2);
		write_thresh(blg_pkg::REG_BAT_THRESH_3, b3);
		write_thresh(blg_pkg::REG_CHG_THRESH_0, c0);
		write_thresh(blg_pkg::REG_CHG_THRESH_1, c1);
		write_thresh(blg_pkg::REG_CHG_THRESH_2, c2);
		write_thresh(blg_pkg::REG_CHG_THRESH_3, c3);
	endtask

	// result side: changing stall styles plus one long hold-off
	initial begin : sink
		sink_style_t style;
		int unsigned span;
		int unsigned on_len;
		int unsigned off_len;
		int unsigned i;
		bit          held_off;
		m_tready = 1'b0;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			style = sink_style_t'($urandom_range(0, 3));
			span = $urandom_range(20, 300);
			on_len = $urandom_range(1, 8);
			off_len = $urandom_range(1, 8);
			for (i = 0; i < span; i++) begin
				@(negedge clk);
				if (!held_off && ticks_sent > 200) begin
					held_off = 1'b1;
					// input side keeps offering, so the block fills up and stalls it
					m_tready <= 1'b0;
					repeat (400) @(negedge clk);
				end
				case (style)
					SINK_OPEN: m_tready <= 1'b1;
					SINK_BUSY: m_tready <= ($urandom_range(0, 3) != 0);
					SINK_CHOKED: m_tready <= ($urandom_range(0, 9) < 3);
					default: m_tready <= ((i % (on_len + off_len)) < on_len);
				endcase
			end
		end
	end

	// run limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = blg_pkg::REG_BAT_THRESH_0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: both sides of every default bound, sample extremes
		load_thresholds(12'd600, 12'd650, 12'd700, 12'd750,
		                12'd700, 12'd750, 12'd800, 12'd850);
		send_tick(12'd0, 1'b0);
		send_tick(12'd600, 1'b0);
		send_tick(12'd601, 1'b0);
		send_tick(12'd650, 1'b0);
		send_tick(12'd651, 1'b0);
		send_tick(12'd700, 1'b0);
		send_tick(12'd701, 1'b0);
		send_tick(12'd750, 1'b0);
		send_tick(12'd751, 1'b0);
		send_tick(12'd4095, 1'b0);
		send_tick(12'd0, 1'b1);
		send_tick(12'd700, 1'b1);
		send_tick(12'd701, 1'b1);
		send_tick(12'd750, 1'b1);
		send_tick(12'd751, 1'b1);
		send_tick(12'd800, 1'b1);
		send_tick(12'd801, 1'b1);
		send_tick(12'd850, 1'b1);
		send_tick(12'd851, 1'b1);
		send_tick(12'd4095, 1'b1);
		send_tick(12'h555, 1'b0);
		send_tick(12'hAAA, 1'b1);
		send_tick(12'hAAA, 1'b0);
		send_tick(12'h555, 1'b1);
		send_tick(12'hFFF, 1'b0);

		// random ticks during start-up under extreme, misordered and random bounds
		drain();
		load_thresholds('0, '0, '0, '0, '0, '0, '0, '0);
		send_noise(100);
		drain();
		load_thresholds('1, '1, '1, '1, '1, '1, '1, '1);
		send_noise(100);
		drain();
		load_thresholds(12'd3000, 12'd1000, 12'd2000, 12'd500,
		                12'd3500, 12'd100, 12'd2500, 12'd4000);
		send_noise(100);
		drain();
		load_thresholds(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
		                12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
		                12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
		                12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
		send_noise(150);

		// end start-up charging at full voltage, so the shown level sits at the top
		drain();
		load_thresholds(12'd1000, 12'd1500, 12'd2000, 12'd2500,
		                12'd100, 12'd300, 12'd500, 12'd700);
		send_band(blg_pkg::STARTUP_DELAY - ticks_sent, 701, 4095, 1'b1);

		// charge timer runs at the top
		send_band(20, 701, 4095, 1'b1);

		// discharging at the top, then below it: slew count and unfull delay run
		send_band(15, 2501, 4095, 1'b0);
		send_band(15, 1001, 2500, 1'b0);

		// zero level while discharging counts toward low battery, then anything goes
		send_band(15, 0, 1000, 1'b0);
		send_noise(10);

		drain();
		repeat (20) @(negedge clk);
		if (bad_readings == 0 && readings_owed == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/blg_pkg.sv
hw/rtl/blg_classify.sv
hw/rtl/blg_tracker.sv
hw/rtl/battery_level_gauge.sv
sim/battery_level_gauge_checker.sv
sim/battery_level_gauge_tb.sv
